// ===== sv/jac_pkg.sv =====
// Shared types, constants and register indexes for the joystick axis conditioner.
// No dependencies; every other file refers to this package by scoped names.
package jac_pkg;

    // Field widths
    localparam int SAMPLE_BITS    = 12;
    localparam int COEF_FRAC_BITS = 15;
    localparam int WEIGHT_W       = 16;
    localparam int BYTE_W         = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;
    localparam logic [BYTE_W-1:0]      OUT_TOP    = '1;

    // Filter accumulator
    localparam int PROD_W = SAMPLE_BITS + WEIGHT_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int FILT_W = ACC_W - COEF_FRAC_BITS;

    // value*255/full_scale via reciprocal multiply: floor(x*M / 2^SHIFT)
    localparam int SX_W        = SAMPLE_BITS + BYTE_W;
    localparam int SCALE_SHIFT = 2 * SAMPLE_BITS + BYTE_W;
    localparam int SCALE_M_W   = SAMPLE_BITS + BYTE_W + 1;
    localparam logic [SCALE_M_W-1:0] SCALE_MULT = SCALE_M_W'(
        ((64'd1 << SCALE_SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE));
    localparam int SP_W = SX_W + SCALE_M_W;

    // Calibration arithmetic
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int NUM_W  = DIFF_W + BYTE_W + 1;
    localparam int MAG_W  = SAMPLE_BITS + BYTE_W;
    localparam int Q_W    = MAG_W + 2;
    localparam int CNT_W  = $clog2(MAG_W + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREV_W    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUR_W     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_MIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_MID   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_MAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MID   = 3'd6;

    // Reset values
    localparam logic [WEIGHT_W-1:0]    RST_PREV_W  = 16'd0;
    localparam logic [WEIGHT_W-1:0]    RST_CUR_W   = 16'd32768;
    localparam logic [SAMPLE_BITS-1:0] RST_CAL_MIN = '0;
    localparam logic [SAMPLE_BITS-1:0] RST_CAL_MID = SAMPLE_BITS'(2048);
    localparam logic [SAMPLE_BITS-1:0] RST_CAL_MAX = SAMPLE_BITS'(4095);
    localparam logic [BYTE_W-1:0]      RST_OUT_MID = 8'd127;

    typedef struct packed {
        logic                   invert;
        logic [WEIGHT_W-1:0]    prev_w;
        logic [WEIGHT_W-1:0]    cur_w;
        logic [SAMPLE_BITS-1:0] cal_min;
        logic [SAMPLE_BITS-1:0] cal_mid;
        logic [SAMPLE_BITS-1:0] cal_max;
        logic [BYTE_W-1:0]      out_mid;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_FILT,
        S_SCL_R,
        S_SCL_F,
        S_DIV_INIT,
        S_DIV,
        S_FIN
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic capture;
        logic prod;
        logic filt;
        logic scl_raw;
        logic scl_filt;
        logic div_init;
        logic div_step;
        logic finish;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_status;

endpackage

// ===== sv/joystick_axis_conditioner_top.sv =====
// Joystick axis conditioner: one sample in, one conditioned result out.
// Each item runs to completion before the next sample is accepted: the filter multiply,
// the two reciprocal scalings, the bit-per-cycle restoring divider of the calibration
// map and the final saturation.
// A new sample is taken while the previous
// result still sits unread in the output register; only a second finished result waits.
// Configuration is written through a plain write port and must be written while idle.
// Depends on jac_pkg, jac_cfg_regs, jac_ctrl and jac_datapath.
module joystick_axis_conditioner_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [jac_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [jac_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [jac_pkg::SAMPLE_BITS-1:0]  i_sample,
    // output channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [jac_pkg::SAMPLE_BITS-1:0]  o_raw_value,
    output logic [jac_pkg::BYTE_W-1:0]       o_raw_scaled,
    output logic [jac_pkg::SAMPLE_BITS-1:0]  o_filtered_value,
    output logic [jac_pkg::BYTE_W-1:0]       o_filtered_scaled,
    output logic [jac_pkg::BYTE_W-1:0]       o_calibrated_scaled,
    output logic                             o_out_of_range
);

    jac_pkg::t_cfg    w_cfg;
    jac_pkg::t_cmd    w_cmd;
    jac_pkg::t_status w_status;

    // Register file
    jac_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Controller
    jac_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (o_stall)
    );

    // Datapath
    jac_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (w_cfg),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .i_sample            (i_sample),
        .i_stall             (i_stall),
        .o_valid             (o_valid),
        .o_raw_value         (o_raw_value),
        .o_raw_scaled        (o_raw_scaled),
        .o_filtered_value    (o_filtered_value),
        .o_filtered_scaled   (o_filtered_scaled),
        .o_calibrated_scaled (o_calibrated_scaled),
        .o_out_of_range      (o_out_of_range)
    );

endmodule

// ===== sv/jac_cfg_regs.sv =====
// Configuration register file for the joystick axis conditioner.
// Depends on jac_pkg (register indexes, reset values, t_cfg).
module jac_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [jac_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [jac_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output jac_pkg::t_cfg                 o_cfg
);

    jac_pkg::t_cfg r_cfg;

    // Register writes; data is truncated to each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.invert  <= 1'b0;
            r_cfg.prev_w  <= jac_pkg::RST_PREV_W;
            r_cfg.cur_w   <= jac_pkg::RST_CUR_W;
            r_cfg.cal_min <= jac_pkg::RST_CAL_MIN;
            r_cfg.cal_mid <= jac_pkg::RST_CAL_MID;
            r_cfg.cal_max <= jac_pkg::RST_CAL_MAX;
            r_cfg.out_mid <= jac_pkg::RST_OUT_MID;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                jac_pkg::CFG_INVERT:  r_cfg.invert  <= i_cfg_data[0];
                jac_pkg::CFG_PREV_W:  r_cfg.prev_w  <= i_cfg_data[jac_pkg::WEIGHT_W-1:0];
                jac_pkg::CFG_CUR_W:   r_cfg.cur_w   <= i_cfg_data[jac_pkg::WEIGHT_W-1:0];
                jac_pkg::CFG_CAL_MIN: r_cfg.cal_min <= i_cfg_data[jac_pkg::SAMPLE_BITS-1:0];
                jac_pkg::CFG_CAL_MID: r_cfg.cal_mid <= i_cfg_data[jac_pkg::SAMPLE_BITS-1:0];
                jac_pkg::CFG_CAL_MAX: r_cfg.cal_max <= i_cfg_data[jac_pkg::SAMPLE_BITS-1:0];
                jac_pkg::CFG_OUT_MID: r_cfg.out_mid <= i_cfg_data[jac_pkg::BYTE_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/jac_ctrl.sv =====
// Sequencing state machine for the joystick axis conditioner.
// Depends on jac_pkg (t_state, t_cmd, t_status).
module jac_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  jac_pkg::t_status i_status,
    output jac_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    jac_pkg::t_state r_state;
    jac_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jac_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            jac_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = jac_pkg::S_PROD;
                end
            end
            jac_pkg::S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = jac_pkg::S_FILT;
            end
            jac_pkg::S_FILT: begin
                o_cmd.filt = 1'b1;
                n_state    = jac_pkg::S_SCL_R;
            end
            jac_pkg::S_SCL_R: begin
                o_cmd.scl_raw = 1'b1;
                n_state       = jac_pkg::S_SCL_F;
            end
            jac_pkg::S_SCL_F: begin
                o_cmd.scl_filt = 1'b1;
                n_state        = jac_pkg::S_DIV_INIT;
            end
            jac_pkg::S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = jac_pkg::S_DIV;
            end
            jac_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = jac_pkg::S_FIN;
                end
            end
            jac_pkg::S_FIN: begin
                // wait for the output register to be free
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = jac_pkg::S_IDLE;
                end
            end
            default: n_state = jac_pkg::S_IDLE;
        endcase
    end

    assign o_busy = (r_state != jac_pkg::S_IDLE);

endmodule

// ===== sv/jac_datapath.sv =====
// Filter, scaling, calibration divider and output register of the axis conditioner.
// Depends on jac_pkg (widths, constants, t_cfg, t_cmd, t_status).
module jac_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  jac_pkg::t_cfg                    i_cfg,
    input  jac_pkg::t_cmd                    i_cmd,
    output jac_pkg::t_status                 o_status,
    input  logic [jac_pkg::SAMPLE_BITS-1:0]  i_sample,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic [jac_pkg::SAMPLE_BITS-1:0]  o_raw_value,
    output logic [jac_pkg::BYTE_W-1:0]       o_raw_scaled,
    output logic [jac_pkg::SAMPLE_BITS-1:0]  o_filtered_value,
    output logic [jac_pkg::BYTE_W-1:0]       o_filtered_scaled,
    output logic [jac_pkg::BYTE_W-1:0]       o_calibrated_scaled,
    output logic                             o_out_of_range
);

    localparam int SB = jac_pkg::SAMPLE_BITS;
    localparam int BW = jac_pkg::BYTE_W;

    // Filter and scaling registers
    logic [SB-1:0]               r_raw;
    logic [SB-1:0]               r_prev;
    logic [jac_pkg::PROD_W-1:0]  r_pc;
    logic [jac_pkg::PROD_W-1:0]  r_pp;
    logic [SB-1:0]               r_filt;
    logic [jac_pkg::SX_W-1:0]    r_sx;
    logic [jac_pkg::SP_W-1:0]    r_sprod;
    logic [BW-1:0]               r_raw_sc;
    logic [BW-1:0]               r_filt_sc;

    // Calibration registers
    logic                              r_upper;
    logic signed [jac_pkg::DIFF_W-1:0] r_diff;
    logic signed [jac_pkg::DIFF_W-1:0] r_den;
    logic [BW-1:0]                     r_k;
    logic signed [jac_pkg::NUM_W-1:0]  r_num;

    // Divider registers
    logic [jac_pkg::MAG_W-1:0] r_quo;
    logic [SB-1:0]             r_rem;
    logic [SB-1:0]             r_dvs;
    logic                      r_qneg;
    logic                      r_zero;
    logic [jac_pkg::CNT_W-1:0] r_cnt;

    logic r_out_valid;

    // Combinational helpers
    logic [SB-1:0]                     w_raw_in;
    logic [jac_pkg::ACC_W-1:0]         w_acc;
    logic [jac_pkg::FILT_W-1:0]        w_shifted;
    logic [SB-1:0]                     w_filt_sat;
    logic [BW-1:0]                     w_sc_byte;
    logic                              w_upper;
    logic [SB-1:0]                     w_base;
    logic signed [jac_pkg::NUM_W-1:0]  w_diff_s;
    logic signed [jac_pkg::NUM_W-1:0]  w_k_s;
    logic [jac_pkg::NUM_W-1:0]         w_num_abs;
    logic [jac_pkg::DIFF_W-1:0]        w_den_abs;
    logic [SB:0]                       w_trial;
    logic                              w_ge;
    logic [SB:0]                       w_sub;
    logic signed [jac_pkg::Q_W-1:0]    w_mag_s;
    logic signed [jac_pkg::Q_W-1:0]    w_q;
    logic signed [jac_pkg::Q_W-1:0]    w_qo;
    logic [BW-1:0]                     w_cal;
    logic                              w_flag;

    // Input inversion
    assign w_raw_in = i_cfg.invert ? (jac_pkg::FULL_SCALE - i_sample) : i_sample;

    // Two-tap sum, truncate, saturate
    assign w_acc      = jac_pkg::ACC_W'(r_pc) + jac_pkg::ACC_W'(r_pp);
    assign w_shifted  = w_acc[jac_pkg::ACC_W-1:jac_pkg::COEF_FRAC_BITS];
    assign w_filt_sat = (|w_shifted[jac_pkg::FILT_W-1:SB]) ? jac_pkg::FULL_SCALE
                                                          : w_shifted[SB-1:0];

    // Reciprocal product down to a byte
    assign w_sc_byte = r_sprod[jac_pkg::SCALE_SHIFT+BW-1:jac_pkg::SCALE_SHIFT];

    // Segment select for the calibration map
    assign w_upper = (r_filt >= i_cfg.cal_mid);
    assign w_base  = w_upper ? i_cfg.cal_mid : i_cfg.cal_min;

    // Sign-extended difference and zero-extended gain for the numerator product
    assign w_diff_s = jac_pkg::NUM_W'(r_diff);
    assign w_k_s    = $signed(jac_pkg::NUM_W'(r_k));

    // Magnitudes for the unsigned divider
    assign w_num_abs = r_num[jac_pkg::NUM_W-1] ? jac_pkg::NUM_W'(-r_num)
                                               : jac_pkg::NUM_W'(r_num);
    assign w_den_abs = r_den[jac_pkg::DIFF_W-1] ? jac_pkg::DIFF_W'(-r_den)
                                                : jac_pkg::DIFF_W'(r_den);

    // One restoring division step
    assign w_trial = {r_rem, r_quo[jac_pkg::MAG_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_sub   = w_trial - {1'b0, r_dvs};

    // Signed quotient, segment offset and saturation
    assign w_mag_s = $signed(jac_pkg::Q_W'(r_quo));
    assign w_q     = r_qneg ? -w_mag_s : w_mag_s;
    assign w_qo    = r_upper ? (w_q + $signed(jac_pkg::Q_W'(i_cfg.out_mid))) : w_q;

    always_comb begin
        priority if (r_zero) begin
            w_cal  = i_cfg.out_mid;
            w_flag = 1'b1;
        end else if (w_qo[jac_pkg::Q_W-1]) begin
            w_cal  = '0;
            w_flag = 1'b1;
        end else if (w_qo > $signed(jac_pkg::Q_W'(jac_pkg::OUT_TOP))) begin
            w_cal  = jac_pkg::OUT_TOP;
            w_flag = 1'b1;
        end else begin
            w_cal  = w_qo[BW-1:0];
            w_flag = 1'b0;
        end
    end

    // Previous-sample state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_cmd.filt) begin
            r_prev <= r_raw;
        end
    end

    // Datapath payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_raw <= w_raw_in;
        end
        if (i_cmd.prod) begin
            r_pc <= jac_pkg::PROD_W'(r_raw) * jac_pkg::PROD_W'(i_cfg.cur_w);
            r_pp <= jac_pkg::PROD_W'(r_prev) * jac_pkg::PROD_W'(i_cfg.prev_w);
            r_sx <= jac_pkg::SX_W'({r_raw, {BW{1'b0}}}) - jac_pkg::SX_W'(r_raw);
        end
        if (i_cmd.filt) begin
            r_filt  <= w_filt_sat;
            r_sprod <= jac_pkg::SP_W'(r_sx) * jac_pkg::SP_W'(jac_pkg::SCALE_MULT);
        end
        if (i_cmd.scl_raw) begin
            r_raw_sc <= w_sc_byte;
            r_sx     <= jac_pkg::SX_W'({r_filt, {BW{1'b0}}}) - jac_pkg::SX_W'(r_filt);
            r_upper  <= w_upper;
            r_diff   <= $signed({1'b0, r_filt}) - $signed({1'b0, w_base});
            r_k      <= w_upper ? (jac_pkg::OUT_TOP - i_cfg.out_mid) : i_cfg.out_mid;
            r_den    <= w_upper ? ($signed({1'b0, i_cfg.cal_max}) - $signed({1'b0, i_cfg.cal_mid}))
                                : ($signed({1'b0, i_cfg.cal_mid}) - $signed({1'b0, i_cfg.cal_min}));
        end
        if (i_cmd.scl_filt) begin
            r_sprod <= jac_pkg::SP_W'(r_sx) * jac_pkg::SP_W'(jac_pkg::SCALE_MULT);
            r_num   <= w_diff_s * w_k_s;
        end
        if (i_cmd.div_init) begin
            r_filt_sc <= w_sc_byte;
            r_quo     <= w_num_abs[jac_pkg::MAG_W-1:0];
            r_dvs     <= w_den_abs[SB-1:0];
            r_rem     <= '0;
            r_qneg    <= r_num[jac_pkg::NUM_W-1] ^ r_den[jac_pkg::DIFF_W-1];
            r_zero    <= (r_den == '0);
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_sub[SB-1:0] : w_trial[SB-1:0];
            r_quo <= {r_quo[jac_pkg::MAG_W-2:0], w_ge};
        end
    end

    // Divider step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_init) begin
            r_cnt <= jac_pkg::CNT_W'(jac_pkg::MAG_W);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - jac_pkg::CNT_W'(1);
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload, loaded only when the register is free
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_raw_value         <= r_raw;
            o_raw_scaled        <= r_raw_sc;
            o_filtered_value    <= r_filt;
            o_filtered_scaled   <= r_filt_sc;
            o_calibrated_scaled <= w_cal;
            o_out_of_range      <= w_flag;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status.div_last = (r_cnt == jac_pkg::CNT_W'(1));
    assign o_status.out_free = !r_out_valid || !i_stall;

endmodule

// ===== sv/jac_checker.sv =====
// Port-level checks for the joystick axis conditioner, bound to the top level.
// Depends on jac_pkg and joystick_axis_conditioner_top.
module jac_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_we,
    input logic [jac_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input logic [jac_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input logic                             i_valid,
    input logic                             o_stall,
    input logic [jac_pkg::SAMPLE_BITS-1:0]  i_sample,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic [jac_pkg::SAMPLE_BITS-1:0]  o_raw_value,
    input logic [jac_pkg::BYTE_W-1:0]       o_raw_scaled,
    input logic [jac_pkg::SAMPLE_BITS-1:0]  o_filtered_value,
    input logic [jac_pkg::BYTE_W-1:0]       o_filtered_scaled,
    input logic [jac_pkg::BYTE_W-1:0]       o_calibrated_scaled,
    input logic                             o_out_of_range
);

    // An accepted transaction keeps the input side busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accepted transaction");

    // A new result appears only as the sequence ends and the input side frees up
    a_result_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(o_stall) && !o_stall))
        else $error("result appeared outside the end of an item");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_raw_value)
            && $stable(o_filtered_value) && $stable(o_calibrated_scaled)
            && $stable(o_out_of_range)))
        else $error("stalled result changed");

    // Full-scale values map to the top byte code
    a_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_filtered_value == jac_pkg::FULL_SCALE)
            && (o_raw_value == jac_pkg::FULL_SCALE))
        |-> ((o_filtered_scaled == jac_pkg::OUT_TOP) && (o_raw_scaled == jac_pkg::OUT_TOP)))
        else $error("full-scale value not scaled to top code");

endmodule

bind joystick_axis_conditioner_top jac_checker u_jac_checker (.*);
